// ----- hdl/worst_fit_demand_assigner_unit_assert.svh -----
// assertion macros shared by the rtl
`ifndef WORST_FIT_DEMAND_ASSIGNER_UNIT_ASSERT_SVH
`define WORST_FIT_DEMAND_ASSIGNER_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define WFDA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wfda assertion failed");

// next-cycle implication, held off during reset
`define WFDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wfda assertion failed");

`endif

// ----- hdl/wfda_pkg.sv -----
package wfda_pkg;

    // field widths
    localparam int FUNC_W = 2;
    localparam int SIDX_FW = 5;
    localparam int BW_W = 20;
    localparam int UIDX_FW = 6;
    localparam int MASK_W = 32;
    localparam int STAT_W = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD_CAP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_MASK = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_NEW_SLOT = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_ASSIGN = 2'd3;

    // result codes
    localparam logic [STAT_W-1:0] ST_ASSIGNED = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd2;
    localparam logic [STAT_W-1:0] ST_ACK = 2'd3;

    typedef logic [BW_W-1:0] bw_t;

    // one result transaction
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SIDX_FW-1:0] site;
        bw_t rem;
    } rsp_t;

endpackage

// ----- hdl/worst_fit_demand_assigner_unit.sv -----
// worst-fit demand assigner
// input channel s_*: one transaction per command; s_tuser carries the command
// (load site capacity, load user reach mask, new time slot, assign demand),
// s_tdata the operands. output channel m_*: exactly one result transaction per
// command; m_tuser carries the status, m_tdata the chosen site and the
// bandwidth left on it.
// loads and new time slot go from acceptance through the response state to the result.
// an assignment reads the user's reach mask, then scans the site memory one
// site per cycle (registered read), then writes the grown used flow back; the
// scan pace is set by the single read port of the site memory. a zero demand or
// an out-of-range user skips the scan and answers through the response state.
// one command is in flight at a time; s_tready is high whenever the engine is
// free, even while a finished result still sits in the output register.
// reset clears the control state and the used-flow valid bits, so every site
// starts with zero used flow; capacities and masks hold nothing until loaded.
// a new time slot clears all valid bits at once, no memory sweep is needed.
// if the receiver stalls, the result waits in the output register and the
// engine holds its next result until the register drains.
`include "worst_fit_demand_assigner_unit_assert.svh"

module worst_fit_demand_assigner_unit #(
    parameter int SITE_COUNT = 32,
    parameter int USER_COUNT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // site_index[4:0], capacity[24:5], user_index[30:25], reach_mask[62:31],
    // demand[82:63], zero fill above
    input  logic [87:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // chosen_site[4:0], remaining_after[24:5], zero fill above
    output logic [31:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser
);

    localparam int BW_W = wfda_pkg::BW_W;
    localparam int SIDX_W = (SITE_COUNT > 1) ? $clog2(SITE_COUNT) : 1;
    localparam int UIDX_W = (USER_COUNT > 1) ? $clog2(USER_COUNT) : 1;
    localparam int UEXT_W = (UIDX_W > wfda_pkg::UIDX_FW) ? UIDX_W : wfda_pkg::UIDX_FW;

    // engine states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MASK = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    // input fields
    logic [wfda_pkg::FUNC_W-1:0] in_func;
    logic [wfda_pkg::SIDX_FW-1:0] in_site;
    wfda_pkg::bw_t in_cap;
    logic [wfda_pkg::UIDX_FW-1:0] in_user;
    logic [wfda_pkg::MASK_W-1:0] in_mask;
    wfda_pkg::bw_t in_dem;
    logic [UEXT_W-1:0] in_user_ext;

    assign in_func = s_tuser;
    assign in_site = s_tdata[4:0];
    assign in_cap = s_tdata[24:5];
    assign in_user = s_tdata[30:25];
    assign in_mask = s_tdata[62:31];
    assign in_dem = s_tdata[82:63];
    assign in_user_ext = UEXT_W'(in_user);

    logic site_ok;
    logic user_ok;
    assign site_ok = (32'(in_site) < SITE_COUNT);
    assign user_ok = (32'(in_user) < USER_COUNT);

    // site memory: capacity in the upper field, used flow in the lower
    logic [2*BW_W-1:0] site_mem [SITE_COUNT];
    logic [2*BW_W-1:0] site_rdata;
    logic [SIDX_W-1:0] site_waddr;
    logic [SIDX_W-1:0] site_raddr;
    logic cap_we;
    logic used_we;
    wfda_pkg::bw_t used_wdata;

    // user reach memory, single port
    logic [wfda_pkg::MASK_W-1:0] user_mem [USER_COUNT];
    logic [wfda_pkg::MASK_W-1:0] user_rdata;
    logic [UIDX_W-1:0] user_addr;
    logic user_we;

    // control and datapath registers
    logic [2:0] state_reg, state_next;
    logic [SITE_COUNT-1:0] used_valid_reg, used_valid_next;
    logic [SITE_COUNT-1:0] reach_reg, reach_next;
    logic [SIDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic found_reg, found_next;
    logic [SIDX_W-1:0] best_idx_reg, best_idx_next;
    wfda_pkg::bw_t best_rem_reg, best_rem_next;
    wfda_pkg::bw_t best_used_reg, best_used_next;
    wfda_pkg::bw_t dem_reg, dem_next;
    wfda_pkg::rsp_t rsp_reg, rsp_next;
    logic out_valid_reg, out_valid_next;
    wfda_pkg::rsp_t out_reg, out_next;

    // current site under comparison
    wfda_pkg::bw_t cur_cap;
    wfda_pkg::bw_t cur_used;
    wfda_pkg::bw_t cur_rem;
    logic cur_ok;
    logic cur_take;
    logic scan_last;
    logic accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept = s_tvalid && s_tready;

    assign cur_cap = site_rdata[2*BW_W-1:BW_W];
    assign cur_used = used_valid_reg[cmp_idx_reg] ? site_rdata[BW_W-1:0] : '0;
    assign cur_rem = cur_cap - cur_used;
    assign cur_ok = reach_reg[cmp_idx_reg] && (cur_used <= cur_cap) && (cur_rem >= dem_reg);
    assign cur_take = cur_ok && (!found_reg || (cur_rem > best_rem_reg));
    assign scan_last = (cmp_idx_reg == SIDX_W'(SITE_COUNT - 1));

    always_ff @(posedge clk)
    begin
        if (cap_we)
        begin
            site_mem[site_waddr][2*BW_W-1:BW_W] <= in_cap;
        end
        if (used_we)
        begin
            site_mem[site_waddr][BW_W-1:0] <= used_wdata;
        end
        site_rdata <= site_mem[site_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (user_we)
        begin
            user_mem[user_addr] <= in_mask;
        end
        user_rdata <= user_mem[user_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        used_valid_next = used_valid_reg;
        reach_next = reach_reg;
        cmp_idx_next = cmp_idx_reg;
        found_next = found_reg;
        best_idx_next = best_idx_reg;
        best_rem_next = best_rem_reg;
        best_used_next = best_used_reg;
        dem_next = dem_reg;
        rsp_next = rsp_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next = out_reg;

        cap_we = 1'b0;
        used_we = 1'b0;
        user_we = 1'b0;
        site_waddr = in_site[SIDX_W-1:0];
        site_raddr = cmp_idx_reg;
        user_addr = in_user_ext[UIDX_W-1:0];
        used_wdata = best_used_reg + dem_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dem_next = in_dem;
                    rsp_next = '{status: wfda_pkg::ST_ACK, site: '0, rem: '0};
                    state_next = S_RESP;
                    case (in_func)
                        wfda_pkg::FUNC_LOAD_CAP:
                        begin
                            cap_we = site_ok;
                        end
                        wfda_pkg::FUNC_LOAD_MASK:
                        begin
                            user_we = user_ok;
                        end
                        wfda_pkg::FUNC_NEW_SLOT:
                        begin
                            used_valid_next = '0;
                        end
                        default:
                        begin
                            // assignment: zero demand and unknown users answer at once
                            if (in_dem == '0)
                            begin
                                rsp_next.status = wfda_pkg::ST_ZERO;
                            end
                            else if (!user_ok)
                            begin
                                rsp_next.status = wfda_pkg::ST_NOFIT;
                            end
                            else
                            begin
                                state_next = S_MASK;
                            end
                        end
                    endcase
                end
            end
            S_MASK:
            begin
                // mask arrives now; start the site scan at site zero
                reach_next = user_rdata[SITE_COUNT-1:0];
                site_raddr = '0;
                cmp_idx_next = '0;
                found_next = 1'b0;
                best_idx_next = '0;
                best_rem_next = '0;
                best_used_next = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                site_raddr = cmp_idx_reg + SIDX_W'(1);
                if (cur_take)
                begin
                    found_next = 1'b1;
                    best_idx_next = cmp_idx_reg;
                    best_rem_next = cur_rem;
                    best_used_next = cur_used;
                end
                if (scan_last)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    cmp_idx_next = cmp_idx_reg + SIDX_W'(1);
                end
            end
            S_WRITE:
            begin
                // grow the winner's used flow
                site_waddr = best_idx_reg;
                if (found_reg)
                begin
                    used_we = 1'b1;
                    used_valid_next[best_idx_reg] = 1'b1;
                    rsp_next.status = wfda_pkg::ST_ASSIGNED;
                    rsp_next.site = wfda_pkg::SIDX_FW'(best_idx_reg);
                    rsp_next.rem = best_rem_reg - dem_reg;
                end
                else
                begin
                    rsp_next = '{status: wfda_pkg::ST_NOFIT, site: '0, rem: '0};
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_next = rsp_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_valid_reg <= used_valid_next;
            out_valid_reg <= out_valid_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reach_reg <= reach_next;
        cmp_idx_reg <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_rem_reg <= best_rem_next;
        best_used_reg <= best_used_next;
        dem_reg <= dem_next;
        rsp_reg <= rsp_next;
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser = out_reg.status;
    assign m_tdata = {7'd0, out_reg.rem, out_reg.site};

    // the best candidate always covers the demand
    `WFDA_ASSERT_NOW(a_best_covers, clk, rst_n,
        (state_reg == S_SCAN) && found_reg, best_rem_reg >= dem_reg)
    // an assignment marks the winner's used flow as live
    `WFDA_ASSERT_NEXT(a_used_marked, clk, rst_n,
        (state_reg == S_WRITE) && found_reg, used_valid_reg[$past(best_idx_reg)])
    // results other than an assignment carry no site and no bandwidth
    `WFDA_ASSERT_NOW(a_unassigned_zero, clk, rst_n,
        m_tvalid && (m_tuser != wfda_pkg::ST_ASSIGNED), m_tdata == 32'd0)
    // a zero demand never starts a scan
    `WFDA_ASSERT_NEXT(a_zero_skips, clk, rst_n,
        accept && (in_func == wfda_pkg::FUNC_ASSIGN) && (in_dem == '0), state_reg == S_RESP)
    // a new time slot clears every used flow
    `WFDA_ASSERT_NEXT(a_slot_clears, clk, rst_n,
        accept && (in_func == wfda_pkg::FUNC_NEW_SLOT), used_valid_reg == '0)

endmodule
